// ===== src/keyed_session_table_defines.svh =====
// ----------------------------------------------------------------------------
// keyed_session_table assertion macros
// shared concurrent assertion forms for the session table rtl
// ----------------------------------------------------------------------------
`ifndef KEYED_SESSION_TABLE_DEFINES_SVH
`define KEYED_SESSION_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed_session_table: assertion failed");

// next-cycle implication, checked out of reset
`define KST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_session_table: assertion failed");

`endif

// ===== src/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// types and constants shared by the session table entries and the top level
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int unsigned KST_ENTRIES = 16;
  localparam int unsigned ID_W        = 64;
  localparam int unsigned STATUS_W    = 8;
  localparam int unsigned KEYNUM_W    = 32;
  localparam int unsigned KEYWORD_W   = 64;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned RC_W        = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [RC_W-1:0] RC_OK        = 2'd0;
  localparam logic [RC_W-1:0] RC_NO_SPACE  = 2'd1;
  localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } kst_state_e;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]      client;
    logic [ID_W-1:0]      server;
    logic [STATUS_W-1:0]  status;
    logic [KEYNUM_W-1:0]  key_number;
    logic [KEYWORD_W-1:0] key_word;
  } kst_entry_t;

  // control broadcast from the sequencer to every entry
  typedef struct packed {
    logic hit_load;      // capture compare flags for the beat being accepted
    logic wr_en;         // write the granted entry this cycle
    logic wr_use_match;  // grant follows the match chain, else the free chain
  } kst_ctl_t;

endpackage

`default_nettype wire

// ===== src/keyed_session_table.sv =====
// ----------------------------------------------------------------------------
// keyed_session_table
// Session key table of TABLE_ENTRIES records, looked up by client and server
// identifier. A write beat updates the lowest entry whose identifiers match,
// else fills the lowest all-zero entry, else reports no space; a read beat
// returns the lowest matching entry or reports not found. Each beat gives one
// result beat. Every entry compares its identifiers against the beat as it
// is accepted and registers the flags, then in the look state the first-hit
// chain through the entries picks the slot, the write lands and the result
// is registered. The look state waits while a previous result is still
// stalled at the output. The table resets to all zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_session_table_defines.svh"

module keyed_session_table
  import kst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = KST_ENTRIES
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic                 op_i,
  input  wire logic [ID_W-1:0]      client_id_i,
  input  wire logic [ID_W-1:0]      server_id_i,
  input  wire logic [STATUS_W-1:0]  rec_status_i,
  input  wire logic [KEYNUM_W-1:0]  key_number_i,
  input  wire logic [KEYWORD_W-1:0] key_word_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [RC_W-1:0]      result_code_o,
  output      logic [SLOT_W-1:0]    slot_o,
  output      logic [STATUS_W-1:0]  out_status_o,
  output      logic [KEYNUM_W-1:0]  out_key_number_o,
  output      logic [KEYWORD_W-1:0] out_key_word_o
);

  kst_state_e state_q, state_d;
  logic       op_q;
  kst_entry_t cmd_q;
  kst_ctl_t   ctl;
  logic       in_fire;
  logic       look_fire;
  logic       out_free;

  logic [TABLE_ENTRIES:0]   match_chain;
  logic [TABLE_ENTRIES:0]   free_chain;
  logic [TABLE_ENTRIES-1:0] grant_match;
  logic [TABLE_ENTRIES-1:0] grant_free;
  logic [TABLE_ENTRIES-1:0] pick;
  kst_entry_t               entry_rd [TABLE_ENTRIES];

  logic             any_match;
  logic             any_free;
  kst_entry_t       rd_data;
  logic [SLOT_W-1:0] pick_slot;

  logic              out_valid_q;
  logic [RC_W-1:0]   rc_q, rc_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  kst_entry_t        out_q, out_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    look_fire = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          look_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q             <= op_i;
      cmd_q.client     <= client_id_i;
      cmd_q.server     <= server_id_i;
      cmd_q.status     <= rec_status_i;
      cmd_q.key_number <= key_number_i;
      cmd_q.key_word   <= key_word_i;
    end
  end

  assign ctl.hit_load     = in_fire;
  assign ctl.wr_en        = look_fire && (op_q == OP_WRITE);
  assign ctl.wr_use_match = any_match;

  assign match_chain[0] = 1'b0;
  assign free_chain[0]  = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    kst_entry u_entry (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .client_id_i   (client_id_i),
      .server_id_i   (server_id_i),
      .wr_data_i     (cmd_q),
      .match_chain_i (match_chain[i]),
      .free_chain_i  (free_chain[i]),
      .match_chain_o (match_chain[i+1]),
      .free_chain_o  (free_chain[i+1]),
      .grant_match_o (grant_match[i]),
      .grant_free_o  (grant_free[i]),
      .entry_o       (entry_rd[i])
    );
  end

  assign any_match = match_chain[TABLE_ENTRIES];
  assign any_free  = free_chain[TABLE_ENTRIES];
  assign pick      = (op_q == OP_READ || any_match) ? grant_match : grant_free;

  // pick and grant_match are one-hot or empty, so an or of gated terms is the mux
  always_comb begin
    rd_data   = '0;
    pick_slot = '0;
    for (int unsigned k = 0; k < TABLE_ENTRIES; k++) begin
      if (grant_match[k]) begin
        rd_data = rd_data | entry_rd[k];
      end
      if (pick[k]) begin
        pick_slot = pick_slot | SLOT_W'(k);
      end
    end
  end

  always_comb begin
    rc_d   = RC_OK;
    slot_d = pick_slot;
    out_d  = '0;
    if (op_q == OP_WRITE) begin
      if (!any_match && !any_free) begin
        rc_d = RC_NO_SPACE;
      end
    end else begin
      if (any_match) begin
        out_d = rd_data;
      end else begin
        rc_d = RC_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (look_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_fire) begin
      rc_q   <= rc_d;
      slot_q <= slot_d;
      out_q  <= out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_code_o    = rc_q;
  assign slot_o           = slot_q;
  assign out_status_o     = out_q.status;
  assign out_key_number_o = out_q.key_number;
  assign out_key_word_o   = out_q.key_word;

  `KST_ASSERT_NOW(a_grant_onehot, state_q == ST_LOOK, $onehot0(grant_match) && $onehot0(grant_free))
  `KST_ASSERT_NEXT(a_accept_to_look, in_fire, state_q == ST_LOOK)
  `KST_ASSERT_NOW(a_fail_slot_zero, out_valid_q && rc_q != RC_OK, slot_q == '0 && out_q == '0)
  `KST_ASSERT_NOW(a_write_no_data, out_valid_q && rc_q == RC_NO_SPACE, out_q == '0)

endmodule

`default_nettype wire

// ===== src/kst_entry.sv =====
// ----------------------------------------------------------------------------
// kst_entry
// one table entry: record storage, key compare and its link in the
// first-hit priority chains
// ----------------------------------------------------------------------------
`default_nettype none

module kst_entry
  import kst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire kst_ctl_t         ctl_i,
  input  wire logic [ID_W-1:0]  client_id_i,
  input  wire logic [ID_W-1:0]  server_id_i,
  input  wire kst_entry_t       wr_data_i,
  input  wire logic             match_chain_i,
  input  wire logic             free_chain_i,
  output      logic             match_chain_o,
  output      logic             free_chain_o,
  output      logic             grant_match_o,
  output      logic             grant_free_o,
  output      kst_entry_t       entry_o
);

  kst_entry_t entry_q;
  logic       match_q;
  logic       free_q;
  logic       wr_sel;

  // flags are taken against the table as it stands when the beat arrives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (ctl_i.hit_load) begin
      match_q <= (entry_q.client == client_id_i) && (entry_q.server == server_id_i);
      free_q  <= (entry_q == '0);
    end
  end

  assign grant_match_o = match_q && !match_chain_i;
  assign grant_free_o  = free_q && !free_chain_i;
  assign match_chain_o = match_chain_i || match_q;
  assign free_chain_o  = free_chain_i || free_q;

  assign wr_sel = ctl_i.wr_en && (ctl_i.wr_use_match ? grant_match_o : grant_free_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (wr_sel) begin
      entry_q <= wr_data_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== verif/keyed_session_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_session_table_tb
// Sends write and read beats into the session table, keeps a shadow copy of
// the table to predict each result beat, and compares every result field by
// field. Runs directed lookups, updates and zero-identifier cases, then random
// traffic over small and large identifier pools under several idle and stall
// patterns, a long output hold-off, and finally fills the table to no space.
// ----------------------------------------------------------------------------
module keyed_session_table_tb;
  import kst_pkg::*;

  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned N_CLIENTS      = 6;
  localparam int unsigned N_SERVERS      = 5;

  localparam logic [ID_W-1:0] CLIENT_A = "client01";
  localparam logic [ID_W-1:0] SERVER_A = "server01";
  localparam logic [ID_W-1:0] CLIENT_B = "client02";
  localparam logic [ID_W-1:0] SERVER_B = "server02";
  localparam logic [ID_W-1:0] CLIENT_C = "client03";
  localparam logic [ID_W-1:0] SERVER_C = "server03";

  typedef struct packed {
    logic [RC_W-1:0]      code;
    logic [SLOT_W-1:0]    slot;
    logic [STATUS_W-1:0]  status;
    logic [KEYNUM_W-1:0]  key_number;
    logic [KEYWORD_W-1:0] key_word;
  } session_result_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 op_i           = OP_WRITE;
  logic [ID_W-1:0]      client_id_i    = '0;
  logic [ID_W-1:0]      server_id_i    = '0;
  logic [STATUS_W-1:0]  rec_status_i   = '0;
  logic [KEYNUM_W-1:0]  key_number_i   = '0;
  logic [KEYWORD_W-1:0] key_word_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [RC_W-1:0]      result_code_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [STATUS_W-1:0]  out_status_o;
  logic [KEYNUM_W-1:0]  out_key_number_o;
  logic [KEYWORD_W-1:0] out_key_word_o;

  kst_entry_t      shadow_table [KST_ENTRIES];
  session_result_t pending_results [$];
  logic [ID_W-1:0] client_pool [N_CLIENTS];
  logic [ID_W-1:0] server_pool [N_SERVERS];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holdoffs_asked     = 0;
  int unsigned holdoffs_done      = 0;
  int unsigned holdoff_left       = 0;
  int unsigned mismatch_count     = 0;

  wire req_beat = in_valid_i && !in_stall_o;
  wire rsp_beat = out_valid_o && !out_stall_i;

  keyed_session_table uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .client_id_i      (client_id_i),
    .server_id_i      (server_id_i),
    .rec_status_i     (rec_status_i),
    .key_number_i     (key_number_i),
    .key_word_i       (key_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_code_o    (result_code_o),
    .slot_o           (slot_o),
    .out_status_o     (out_status_o),
    .out_key_number_o (out_key_number_o),
    .out_key_word_o   (out_key_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // applies one request beat to the shadow table and returns its result
  function automatic session_result_t predict_session(
    input logic                 op,
    input logic [ID_W-1:0]      cid,
    input logic [ID_W-1:0]      sid,
    input logic [STATUS_W-1:0]  st,
    input logic [KEYNUM_W-1:0]  kn,
    input logic [KEYWORD_W-1:0] kw
  );
    session_result_t res;
    int pick;
    int i;
    res  = '0;
    pick = -1;
    // scan downward so the lowest hit wins
    for (i = KST_ENTRIES - 1; i >= 0; i--) begin
      if (shadow_table[i].client == cid && shadow_table[i].server == sid) pick = i;
    end
    if (op == OP_WRITE) begin
      if (pick < 0) begin
        for (i = KST_ENTRIES - 1; i >= 0; i--) begin
          if (shadow_table[i] == '0) pick = i;
        end
      end
      if (pick < 0) begin
        res.code = RC_NO_SPACE;
      end else begin
        shadow_table[pick] = {cid, sid, st, kn, kw};
        res.code = RC_OK;
        res.slot = SLOT_W'(pick);
      end
    end else if (pick < 0) begin
      res.code = RC_NOT_FOUND;
    end else begin
      res.code       = RC_OK;
      res.slot       = SLOT_W'(pick);
      res.status     = shadow_table[pick].status;
      res.key_number = shadow_table[pick].key_number;
      res.key_word   = shadow_table[pick].key_word;
    end
    return res;
  endfunction

  // result beats are checked before this edge's request beat is predicted
  always @(posedge clk_i) begin : track_table
    session_result_t want;
    if (rst_ni) begin
      if (rsp_beat) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_code_o !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, result_code_o);
            mismatch_count++;
          end
          if (slot_o !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot_o);
            mismatch_count++;
          end
          if (out_status_o !== want.status) begin
            $error("out_status: expected %h, got %h", want.status, out_status_o);
            mismatch_count++;
          end
          if (out_key_number_o !== want.key_number) begin
            $error("out_key_number: expected %h, got %h", want.key_number,
                   out_key_number_o);
            mismatch_count++;
          end
          if (out_key_word_o !== want.key_word) begin
            $error("out_key_word: expected %h, got %h", want.key_word, out_key_word_o);
            mismatch_count++;
          end
        end
      end
      if (req_beat) begin
        pending_results.push_back(predict_session(op_i, client_id_i, server_id_i,
                                                  rec_status_i, key_number_i, key_word_i));
      end
    end
  end

  always @(posedge clk_i) begin : drive_receiver
    if (holdoff_left != 0) begin
      out_stall_i  <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_done != holdoffs_asked) begin
      out_stall_i   <= 1'b1;
      holdoff_left  <= HOLDOFF_CYCLES - 1;
      holdoffs_done <= holdoffs_done + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || req_beat || rsp_beat) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("keyed_session_table verification failed");
    $finish;
  end

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // offers one beat after a random gap and returns once it is accepted
  task automatic send_request(
    input logic                 op,
    input logic [ID_W-1:0]      cid,
    input logic [ID_W-1:0]      sid,
    input logic [STATUS_W-1:0]  st,
    input logic [KEYNUM_W-1:0]  kn,
    input logic [KEYWORD_W-1:0] kw
  );
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    client_id_i  <= cid;
    server_id_i  <= sid;
    rec_status_i <= st;
    key_number_i <= kn;
    key_word_i   <= kw;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // identifiers come from the first entries of the pools, zero now and then
  task automatic send_random_session(input int unsigned n_clients,
                                     input int unsigned n_servers);
    logic                 op;
    logic [ID_W-1:0]      cid;
    logic [ID_W-1:0]      sid;
    logic [STATUS_W-1:0]  st;
    logic [KEYNUM_W-1:0]  kn;
    logic [KEYWORD_W-1:0] kw;
    op  = ($urandom_range(1) == 0) ? OP_WRITE : OP_READ;
    cid = ($urandom_range(7) == 0) ? '0 : client_pool[$urandom_range(n_clients - 1)];
    sid = ($urandom_range(7) == 0) ? '0 : server_pool[$urandom_range(n_servers - 1)];
    st  = STATUS_W'($urandom);
    kn  = $urandom;
    kw  = {$urandom, $urandom};
    if ($urandom_range(15) == 0) begin
      st = '0;
      kn = '0;
      kw = '0;
    end
    // all-zero write frees a zero-identifier entry
    if ($urandom_range(39) == 0) begin
      op  = OP_WRITE;
      cid = '0;
      sid = '0;
      st  = '0;
      kn  = '0;
      kw  = '0;
    end
    send_request(op, cid, sid, st, kn, kw);
  endtask

  task automatic test_random_traffic(input int unsigned beats, input int unsigned n_clients,
                                     input int unsigned n_servers);
    repeat (beats) send_random_session(n_clients, n_servers);
  endtask

  task automatic test_empty_lookup();
    // an untouched entry matches zero identifiers
    send_request(OP_READ, '0, '0, '1, '1, '1);
    send_request(OP_READ, '1, '1, '0, '0, '0);
    send_request(OP_READ, CLIENT_A, '0, 8'h5A, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
  endtask

  task automatic test_record_update();
    send_request(OP_WRITE, '1, '1, '1, '1, '1);
    send_request(OP_READ, '1, '1, '0, '0, '0);
    send_request(OP_WRITE, '1, '1, 8'h01, 32'h1, 64'h8000_0000_0000_0000);
    send_request(OP_WRITE, CLIENT_A, SERVER_A, 8'h80, 32'h8000_0000, 64'h5555_5555_5555_5555);
    send_request(OP_READ, '1, '1, '1, '1, '1);
    // client hit with server miss is still a miss
    send_request(OP_READ, CLIENT_A, '1, '0, '0, '0);
    send_request(OP_WRITE, '1, SERVER_A, 8'h7F, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_READ, CLIENT_A, SERVER_A, '0, '0, '0);
  endtask

  task automatic test_zero_identifiers();
    send_request(OP_WRITE, '0, '0, 8'hAA, 32'h1234_5678, 64'hDEAD_BEEF_0BAD_F00D);
    send_request(OP_READ, '0, '0, '0, '0, '0);
    send_request(OP_WRITE, CLIENT_B, SERVER_B, 8'h3C, 32'hC3C3_0000, 64'h0123_4567_89AB_CDEF);
    send_request(OP_WRITE, '0, '0, '0, '0, '0);
    send_request(OP_READ, '0, '0, '1, '1, '1);
    send_request(OP_WRITE, CLIENT_C, '0, 8'h11, 32'h2222_2222, 64'h3333_3333_3333_3333);
    send_request(OP_WRITE, '0, SERVER_C, '0, '0, '0);
    send_request(OP_READ, '0, '0, '0, '0, '0);
  endtask

  task automatic test_backpressure_holdoff();
    set_idling(0, receiver_stall_pct);
    holdoffs_asked++;
    test_random_traffic(40, N_CLIENTS, N_SERVERS);
  endtask

  // fill every free entry with fresh pairs, then one more finds no room
  task automatic test_full_table();
    int unsigned free_slots;
    int unsigned k;
    wait_for_drain();
    free_slots = 0;
    foreach (shadow_table[i]) begin
      if (shadow_table[i] == '0) free_slots++;
    end
    for (k = 0; k <= free_slots; k++) begin
      send_request(OP_WRITE, {32'hF00D_0000, 32'(k)}, {32'h5E55_0000, 32'(k)},
                   8'(k + 1), 32'(k * 7), {$urandom, $urandom});
    end
    send_request(OP_READ, {32'hF00D_0000, 32'hFFFF_FFFF}, '1, '0, '0, '0);
    send_request(OP_WRITE, '0, '0, '0, '0, '0);
    send_request(OP_READ, '0, '0, '0, '0, '0);
  endtask

  initial begin : run_tests
    foreach (shadow_table[i]) shadow_table[i] = '0;
    foreach (client_pool[i]) client_pool[i] = {$urandom, $urandom};
    foreach (server_pool[i]) server_pool[i] = {$urandom, $urandom};
    // near-miss client, one bit away from another
    client_pool[N_CLIENTS - 1] = client_pool[0] ^ (64'd1 << $urandom_range(63));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookup();
    test_record_update();
    test_zero_identifiers();

    // small pools never fill the table, large ones do
    set_idling(0, 0);
    test_random_traffic(350, 2, 2);
    set_idling(61, 0);
    test_random_traffic(350, 2, 2);
    set_idling(0, 61);
    test_random_traffic(400, N_CLIENTS, N_SERVERS);
    set_idling(20, 20);
    test_random_traffic(400, N_CLIENTS, N_SERVERS);
    test_backpressure_holdoff();
    set_idling(20, 20);
    test_full_table();

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("keyed_session_table verification clean");
    end else begin
      $display("keyed_session_table verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/kst_pkg.sv
src/kst_entry.sv
src/keyed_session_table.sv
verif/keyed_session_table_tb.sv
